[hdl/mit_pkg.sv]
package mit_pkg;

    localparam int KEY_BITS = 32;

    typedef enum logic [1:0] {
        KIND_LOAD  = 2'd0,
        KIND_PROBE = 2'd1,
        KIND_CLEAR = 2'd2
    } kind_t;

    typedef enum logic [2:0] {
        ST_LOADED  = 3'd0,
        ST_FULL    = 3'd1,
        ST_MATCH   = 3'd2,
        ST_NOMATCH = 3'd3,
        ST_CLEARED = 3'd4
    } status_t;

    // Item travelling down the cell row.
    // done: key found or inserted; shift: a hole opened behind, pull neighbor down.
    typedef struct packed {
        logic                valid;
        kind_t               kind;
        logic [KEY_BITS-1:0] value;
        logic                done;
        logic                shift;
    } item_t;

endpackage

[hdl/mit_cell.sv]
module mit_cell #(
    parameter int COUNT_BITS = 16
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          advance,
    input  mit_pkg::item_t                item_in,
    input  logic [mit_pkg::KEY_BITS-1:0]  nbr_key,
    input  logic [COUNT_BITS-1:0]         nbr_count,
    output logic [mit_pkg::KEY_BITS-1:0]  key,
    output logic [COUNT_BITS-1:0]         count,
    output mit_pkg::item_t                item_out
);

    localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};
    localparam logic [COUNT_BITS-1:0] COUNT_ONE = COUNT_BITS'(1);

    logic [mit_pkg::KEY_BITS-1:0] key_reg, key_next;
    logic [COUNT_BITS-1:0]        count_reg, count_next;
    mit_pkg::item_t               item_reg, item_next;
    logic                         hit;

    assign hit = item_in.valid && !item_in.done && (count_reg != '0)
                 && (key_reg == item_in.value);

    always_comb begin
        key_next   = key_reg;
        count_next = count_reg;
        item_next  = item_in;
        if (item_in.valid) begin
            if (item_in.shift) begin
                key_next   = nbr_key;
                count_next = nbr_count;
            end else begin
                case (item_in.kind)
                    mit_pkg::KIND_LOAD: begin
                        if (hit) begin
                            if (count_reg != COUNT_MAX) begin
                                count_next = count_reg + COUNT_ONE;
                            end
                            item_next.done = 1'b1;
                        end else if (!item_in.done && count_reg == '0) begin
                            // occupied entries form a prefix: first free cell ends the search
                            key_next       = item_in.value;
                            count_next     = COUNT_ONE;
                            item_next.done = 1'b1;
                        end
                    end
                    mit_pkg::KIND_PROBE: begin
                        if (hit) begin
                            item_next.done = 1'b1;
                            if (count_reg == COUNT_ONE) begin
                                key_next        = nbr_key;
                                count_next      = nbr_count;
                                item_next.shift = 1'b1;
                            end else begin
                                count_next = count_reg - COUNT_ONE;
                            end
                        end
                    end
                    mit_pkg::KIND_CLEAR: begin
                        count_next = '0;
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
            item_reg  <= '0;
        end else if (advance) begin
            count_reg <= count_next;
            item_reg  <= item_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            key_reg <= key_next;
        end
    end

    assign key      = key_reg;
    assign count    = count_reg;
    assign item_out = item_reg;

endmodule

[hdl/multiset_intersection_table.sv]
// A result is registered once its item has passed the input stage and all cells.
// Items enter while earlier ones are still in the row, walk it one cell per cycle
// and stay two cells apart so an entry shift never overlaps the next item.
// The whole row stalls while a result waits on m_tready.
// Reset (aresetn low, synchronous) empties all entries and drops items in flight.
module multiset_intersection_table #(
    parameter int ENTRIES    = 64,
    parameter int COUNT_BITS = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // [31:0] item_value
    input  logic [1:0]  s_tuser,   // [1:0] kind
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // [31:0] echo_value
    output logic [2:0]  m_tuser    // [2:0] status
);

    logic                          advance;
    mit_pkg::item_t                stage0_reg, stage0_next;
    mit_pkg::item_t                item_chain [ENTRIES+1];
    logic [mit_pkg::KEY_BITS-1:0]  key_arr    [ENTRIES];
    logic [COUNT_BITS-1:0]         count_arr  [ENTRIES];
    logic                          m_tvalid_reg;
    mit_pkg::status_t              status_reg, status_next;
    logic [31:0]                   echo_reg, echo_next;
    mit_pkg::item_t                last_item;

    assign advance  = !m_tvalid_reg || m_tready;
    assign s_tready = advance && !stage0_reg.valid;

    always_comb begin
        stage0_next       = '0;
        stage0_next.kind  = mit_pkg::kind_t'(s_tuser);
        stage0_next.value = s_tdata;
        // unused kind is taken and dropped without a result
        stage0_next.valid = s_tvalid && s_tready
                            && (s_tuser != 2'(mit_pkg::KIND_CLEAR) + 2'd1);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            stage0_reg <= '0;
        end else if (advance) begin
            stage0_reg <= stage0_next;
        end
    end

    assign item_chain[0] = stage0_reg;

    for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
        logic [mit_pkg::KEY_BITS-1:0] nbr_key;
        logic [COUNT_BITS-1:0]        nbr_count;
        if (i < ENTRIES - 1) begin : g_mid
            assign nbr_key   = key_arr[i+1];
            assign nbr_count = count_arr[i+1];
        end else begin : g_end
            assign nbr_key   = '0;
            assign nbr_count = '0;
        end
        mit_cell #(
            .COUNT_BITS (COUNT_BITS)
        ) u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .advance   (advance),
            .item_in   (item_chain[i]),
            .nbr_key   (nbr_key),
            .nbr_count (nbr_count),
            .key       (key_arr[i]),
            .count     (count_arr[i]),
            .item_out  (item_chain[i+1])
        );
    end

    assign last_item = item_chain[ENTRIES];

    always_comb begin
        echo_next = last_item.value;
        case (last_item.kind)
            mit_pkg::KIND_LOAD: begin
                status_next = last_item.done ? mit_pkg::ST_LOADED : mit_pkg::ST_FULL;
            end
            mit_pkg::KIND_PROBE: begin
                status_next = last_item.done ? mit_pkg::ST_MATCH : mit_pkg::ST_NOMATCH;
            end
            default: begin
                status_next = mit_pkg::ST_CLEARED;
                echo_next   = '0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (advance) begin
            m_tvalid_reg <= last_item.valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && last_item.valid) begin
            status_reg <= status_next;
            echo_reg   <= echo_next;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = echo_reg;
    assign m_tuser  = status_reg;

    // items stay two cells apart
    a_spacing: assert property (@(posedge aclk) disable iff (!aresetn)
        !(item_chain[0].valid && item_chain[1].valid))
        else $error("adjacent items in cell row");

    // occupied entries stay packed at the low end, except while a clear
    // has emptied the head cell and not yet reached the next one
    a_packed: assert property (@(posedge aclk) disable iff (!aresetn)
        (count_arr[0] == '0
         && !(item_chain[1].valid && item_chain[1].kind == mit_pkg::KIND_CLEAR))
        |-> (count_arr[1] == '0))
        else $error("hole at head of table");

    // a stalled row holds the item about to leave it
    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (last_item.valid && !advance) |=> $stable(last_item))
        else $error("item lost during stall");

    a_clear_echo: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser == mit_pkg::ST_CLEARED) |-> (m_tdata == '0))
        else $error("clear result with nonzero value");

    // a result is produced only for an item that reached the row end
    a_result_src: assert property (@(posedge aclk) disable iff (!aresetn)
        (advance && !last_item.valid) |=> !m_tvalid)
        else $error("result without item");

endmodule

[tb/multiset_intersection_table_tb.sv]
module multiset_intersection_table_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int ENTRIES = 64;
    localparam int COUNT_BITS = 16;
    localparam int unsigned COUNT_MAX = (2 ** COUNT_BITS) - 1;
    localparam logic [1:0] KIND_UNUSED = 2'd3;
    localparam int RANDOM_ITEMS = 1350;
    localparam int IDLE_LIMIT = 4000;
    localparam int HOLD_OFF_CYCLES = 400;

    typedef struct {
        logic [1:0]                   kind;
        logic [mit_pkg::KEY_BITS-1:0] value;
        bit                           no_gap;
    } send_item_t;

    typedef struct packed {
        mit_pkg::status_t             status;
        logic [mit_pkg::KEY_BITS-1:0] echo;
    } table_reply_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata = '0;
    logic [1:0]  s_tuser = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;
    logic [2:0]  m_tuser;

    // count table as the block should hold it
    logic [mit_pkg::KEY_BITS-1:0] held_keys [ENTRIES];
    logic [COUNT_BITS-1:0]        held_counts [ENTRIES];

    send_item_t   items_to_send[$];
    table_reply_t due_replies[$];

    bit rst_done = 1'b0;
    bit in_fire = 1'b0;
    int mismatch_count = 0;
    int replies_seen = 0;
    int items_counted = 0;
    int idle_cycles = 0;
    int send_gap = 0;
    int send_calm = 0;
    int recv_stall = 0;
    int recv_calm = 0;
    int hold_off_left = 0;
    int hold_offs_done = 0;

    always #2 aclk = ~aclk;

    multiset_intersection_table #(
        .ENTRIES    (ENTRIES),
        .COUNT_BITS (COUNT_BITS)
    ) DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    // Applies one item to the count table; returns 0 when the item gives no reply.
    function automatic bit predict_reply(input logic [1:0] kind,
                                         input logic [mit_pkg::KEY_BITS-1:0] val,
                                         output table_reply_t reply);
        int hit;
        int slot;
        hit = -1;
        slot = -1;
        reply.echo = val;
        reply.status = mit_pkg::ST_LOADED;
        for (int i = ENTRIES - 1; i >= 0; i--) begin
            if (held_counts[i] != '0 && held_keys[i] == val)
                hit = i;
            if (held_counts[i] == '0)
                slot = i;
        end
        if (kind == mit_pkg::KIND_LOAD) begin
            if (hit >= 0) begin
                if (held_counts[hit] != COUNT_MAX[COUNT_BITS-1:0])
                    held_counts[hit] = held_counts[hit] + 1'b1;
            end else if (slot >= 0) begin
                held_keys[slot] = val;
                held_counts[slot] = COUNT_BITS'(1);
            end else begin
                reply.status = mit_pkg::ST_FULL;
            end
        end else if (kind == mit_pkg::KIND_PROBE) begin
            if (hit >= 0) begin
                held_counts[hit] = held_counts[hit] - 1'b1;
                reply.status = mit_pkg::ST_MATCH;
            end else begin
                reply.status = mit_pkg::ST_NOMATCH;
            end
        end else if (kind == mit_pkg::KIND_CLEAR) begin
            for (int i = 0; i < ENTRIES; i++)
                held_counts[i] = '0;
            reply.status = mit_pkg::ST_CLEARED;
            reply.echo = '0;
        end else begin
            return 1'b0;
        end
        return 1'b1;
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        else if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // biased toward the extremes and small values so repeats happen
    function automatic logic [mit_pkg::KEY_BITS-1:0] pick_word();
        case ($urandom_range(0, 9))
            0: return 32'h8000_0000;
            1: return 32'h7FFF_FFFF;
            2: return 32'h0000_0000;
            3: return 32'hFFFF_FFFF;
            4: return $urandom_range(0, 15);
            default: return $urandom();
        endcase
    endfunction

    task automatic push_item(input logic [1:0] kind, input logic [mit_pkg::KEY_BITS-1:0] val,
                             input bit no_gap = 1'b0);
        send_item_t it;
        it.kind = kind;
        it.value = val;
        it.no_gap = no_gap;
        items_to_send.push_back(it);
        if (kind != KIND_UNUSED)
            items_counted++;
    endtask

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("ERROR at %0t: %s got %h expected %h", $realtime, what, got, want);
        mismatch_count++;
    endtask

    // sender
    always @(negedge aclk) begin
        send_item_t it;
        if (!rst_done) begin
            s_tvalid <= 1'b0;
        end else if (s_tvalid && !in_fire) begin
            // transfer still pending, hold everything
        end else if (send_gap > 0) begin
            send_gap--;
            s_tvalid <= 1'b0;
        end else if (items_to_send.size() != 0) begin
            it = items_to_send.pop_front();
            s_tvalid <= 1'b1;
            s_tuser <= it.kind;
            s_tdata <= it.value;
            send_gap = (it.no_gap || send_calm > 0) ? 0 : pick_gap();
            if (send_calm > 0)
                send_calm--;
            else if ($urandom_range(0, 149) == 0)
                send_calm = $urandom_range(50, 200);
        end else begin
            s_tvalid <= 1'b0;
        end
    end

    // receiver
    always @(negedge aclk) begin
        if (!rst_done || hold_off_left != 0) begin
            m_tready <= 1'b0;
        end else if (recv_stall > 0) begin
            recv_stall--;
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
            if (recv_calm > 0)
                recv_calm--;
            else if ($urandom_range(0, 299) == 0)
                recv_calm = $urandom_range(50, 300);
            else if ($urandom_range(0, 5) == 0)
                recv_stall = pick_gap();
        end
    end

    // long receiver hold-offs so the row fills and s_tready drops
    always @(negedge aclk) begin
        if (hold_off_left != 0) begin
            hold_off_left <= hold_off_left - 1;
        end else if (hold_offs_done < 2 && replies_seen >= 300 + 500 * hold_offs_done) begin
            hold_off_left <= HOLD_OFF_CYCLES;
            hold_offs_done <= hold_offs_done + 1;
        end
    end

    // predict on input transfers, check output transfers
    always @(posedge aclk) begin
        table_reply_t want;
        in_fire = s_tvalid && s_tready;
        if (in_fire && predict_reply(s_tuser, s_tdata, want))
            due_replies.push_back(want);
        if (m_tvalid === 1'b1 && m_tready) begin
            replies_seen++;
            if (due_replies.size() == 0) begin
                report_mismatch("reply with none due, status/echo", {29'd0, m_tuser}, m_tdata);
            end else begin
                want = due_replies.pop_front();
                if (m_tuser !== want.status)
                    report_mismatch("status", {29'd0, m_tuser}, {29'd0, want.status});
                if (m_tdata !== want.echo)
                    report_mismatch("echo_value", m_tdata, want.echo);
            end
        end
    end

    always @(posedge aclk) begin
        if (rst_done) begin
            if ((s_tvalid && s_tready) || (m_tvalid === 1'b1 && m_tready)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
                if (idle_cycles >= IDLE_LIMIT) begin
                    $display("Mismatches found");
                    $finish;
                end
            end
        end
    end

    initial begin
        logic [mit_pkg::KEY_BITS-1:0] pool[$];
        logic [1:0] kind;
        int pool_size;
        int n_probe;
        int r;

        for (int i = 0; i < ENTRIES; i++) begin
            held_keys[i] = '0;
            held_counts[i] = '0;
        end

        // directed: extremes, repeats, freeing, unused kind, clear echo
        push_item(mit_pkg::KIND_PROBE, 32'h0000_0000);
        push_item(mit_pkg::KIND_LOAD, 32'h8000_0000);
        push_item(mit_pkg::KIND_LOAD, 32'h7FFF_FFFF);
        push_item(mit_pkg::KIND_LOAD, 32'h0000_0000);
        push_item(mit_pkg::KIND_LOAD, 32'hFFFF_FFFF);
        push_item(mit_pkg::KIND_LOAD, 32'h8000_0000);
        push_item(mit_pkg::KIND_PROBE, 32'h8000_0000);
        push_item(mit_pkg::KIND_PROBE, 32'h8000_0000);
        push_item(mit_pkg::KIND_PROBE, 32'h8000_0000);
        push_item(mit_pkg::KIND_PROBE, 32'h7FFF_FFFF);
        push_item(mit_pkg::KIND_PROBE, 32'h7FFF_FFFF);
        push_item(mit_pkg::KIND_LOAD, 32'h0000_0005);
        push_item(KIND_UNUSED, 32'hFFFF_FFFF);
        push_item(mit_pkg::KIND_PROBE, 32'h0000_0005);
        push_item(mit_pkg::KIND_CLEAR, 32'h1234_5678);
        push_item(mit_pkg::KIND_PROBE, 32'hFFFF_FFFF);
        push_item(mit_pkg::KIND_PROBE, 32'h0000_0000);

        // fill the table back to back, then hit it full
        for (int i = 0; i < ENTRIES; i++)
            push_item(mit_pkg::KIND_LOAD, 32'h1000_0000 + i, 1'b1);
        push_item(mit_pkg::KIND_LOAD, 32'hDEAD_BEEF);
        push_item(mit_pkg::KIND_LOAD, 32'h1000_0000);
        push_item(mit_pkg::KIND_PROBE, 32'h1000_0005);
        push_item(mit_pkg::KIND_LOAD, 32'hDEAD_BEEF);
        push_item(mit_pkg::KIND_LOAD, 32'hCAFE_F00D);
        push_item(mit_pkg::KIND_PROBE, 32'hDEAD_BEEF);

        // random: mostly clear / load list / probe list runs, some noise
        while (items_counted < RANDOM_ITEMS) begin
            if ($urandom_range(0, 99) < 85) begin
                push_item(mit_pkg::KIND_CLEAR, $urandom());
                pool_size = ($urandom_range(0, 4) == 0) ?
                            $urandom_range(ENTRIES - 8, ENTRIES + 24) : $urandom_range(1, 24);
                pool.delete();
                for (int j = 0; j < pool_size; j++)
                    pool.push_back(pick_word());
                for (int j = 0; j < pool_size; j++)
                    push_item(mit_pkg::KIND_LOAD, pool[j]);
                for (int j = $urandom_range(0, pool_size); j > 0; j--)
                    push_item(mit_pkg::KIND_LOAD, pool[$urandom_range(0, pool_size - 1)]);
                n_probe = $urandom_range(1, 2 * pool_size + 2);
                for (int j = 0; j < n_probe; j++) begin
                    r = $urandom_range(0, 99);
                    if (r < 75)
                        push_item(mit_pkg::KIND_PROBE, pool[$urandom_range(0, pool_size - 1)]);
                    else if (r < 85)
                        push_item(mit_pkg::KIND_PROBE, pick_word());
                    else if (r < 95)
                        push_item(mit_pkg::KIND_LOAD, pool[$urandom_range(0, pool_size - 1)]);
                    else
                        push_item(KIND_UNUSED, $urandom());
                end
            end else begin
                for (int j = $urandom_range(1, 8); j > 0; j--) begin
                    kind = 2'($urandom_range(0, 3));
                    push_item(kind, pick_word());
                end
            end
        end

        repeat (7) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        rst_done = 1'b1;

        while (items_to_send.size() != 0 || s_tvalid)
            @(posedge aclk);
        while (due_replies.size() != 0)
            @(posedge aclk);
        repeat (ENTRIES + 30) @(posedge aclk);

        if (mismatch_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
